### sv/upe_pkg.sv
// ----------------------------------------------------------------------------
// upe_pkg: shared types and constants of the URL percent encoder
// Character codes, byte classes and the hex digit lookup.
// ----------------------------------------------------------------------------
package upe_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned IdxW  = 3;

  localparam logic [CharW-1:0] ChrPercent = 7'h25;
  localparam logic [CharW-1:0] ChrPlus    = 7'h2B;

  localparam logic [ByteW-1:0] Utf8Lead = 8'hC0;
  localparam logic [ByteW-1:0] Utf8Cont = 8'h80;
  localparam logic [ByteW-1:0] Utf8Mask = 8'h3F;

  // Last character index of each run length, and the first index of the second escape
  localparam logic [IdxW-1:0] IdxLastOne   = 3'd0;
  localparam logic [IdxW-1:0] IdxLastThree = 3'd2;
  localparam logic [IdxW-1:0] IdxLastSix   = 3'd5;
  localparam logic [IdxW-1:0] IdxSecondEsc = 3'd3;

  typedef enum logic [1:0] {
    ClsPass,
    ClsSpace,
    ClsEscAscii,
    ClsEscLatin
  } upe_class_e;

  typedef struct packed {
    logic [CharW-1:0] chr;
    logic             last;
  } upe_char_t;

  // Lowercase hex digit for a nibble
  function automatic logic [CharW-1:0] hex_digit(input logic [3:0] nib);
    logic [CharW-1:0] res;
    if (nib < 4'd10) begin
      res = 7'h30 + {3'd0, nib};
    end else begin
      res = 7'h57 + {3'd0, nib};
    end
    return res;
  endfunction

endpackage

### sv/upe_if.sv
// ----------------------------------------------------------------------------
// upe_in_if / upe_out_if: byte and character channels
// Valid/ready channels carrying the input byte and the encoded character.
// ----------------------------------------------------------------------------
interface upe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface upe_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink (input valid, input out_char, input run_last, output ready);
endinterface

### sv/upe_char_gen.sv
// ----------------------------------------------------------------------------
// upe_char_gen: encoded character selection
// Classifies a byte and picks the character at a given run position.
// ----------------------------------------------------------------------------
module upe_char_gen import upe_pkg::*; (
  input  logic [ByteW-1:0] byte_i,
  input  logic [IdxW-1:0]  idx_i,
  output upe_char_t        char_o
);

  upe_class_e       cls;
  logic [ByteW-1:0] esc_byte;
  logic [IdxW-1:0]  pos;

  always_comb begin
    if (byte_i inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                       8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A,
                       8'h27, 8'h28, 8'h29}) begin
      cls = ClsPass;
    end else if (byte_i == 8'h20) begin
      cls = ClsSpace;
    end else if (!byte_i[ByteW-1]) begin
      cls = ClsEscAscii;
    end else begin
      cls = ClsEscLatin;
    end
  end

  // Pick the byte being escaped (a UTF-8 byte for Latin-1 input) and the position inside its triple
  always_comb begin
    if (cls == ClsEscLatin && idx_i >= IdxSecondEsc) begin
      esc_byte = Utf8Cont | (byte_i & Utf8Mask);
      pos      = idx_i - IdxSecondEsc;
    end else if (cls == ClsEscLatin) begin
      esc_byte = Utf8Lead | {6'd0, byte_i[7:6]};
      pos      = idx_i;
    end else begin
      esc_byte = byte_i;
      pos      = idx_i;
    end
  end

  always_comb begin
    char_o = '0;
    case (cls)
      ClsPass: begin
        char_o.chr  = byte_i[CharW-1:0];
        char_o.last = (idx_i == IdxLastOne);
      end
      ClsSpace: begin
        char_o.chr  = ChrPlus;
        char_o.last = (idx_i == IdxLastOne);
      end
      ClsEscAscii, ClsEscLatin: begin
        case (pos)
          3'd0:    char_o.chr = ChrPercent;
          3'd1:    char_o.chr = hex_digit(esc_byte[7:4]);
          default: char_o.chr = hex_digit(esc_byte[3:0]);
        endcase
        char_o.last = (cls == ClsEscAscii) ? (idx_i == IdxLastThree)
                                           : (idx_i == IdxLastSix);
      end
      default: char_o = '0;
    endcase
  end

endmodule

### sv/url_percent_encoder.sv
// ----------------------------------------------------------------------------
// url_percent_encoder: form-URL encoder, one byte in, a character run out
// Emits the encoded characters of each byte one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one byte per item; out_o carries one character per item,
//   with run_last set on the final character of each byte's run.
//   A passed byte or a space gives one character, an escaped ASCII byte
//   three (%hh), a byte from 0x80 up six (two escaped UTF-8 bytes).
//   An accepted byte is stored in the holding register; its first character
//   moves from there to the output register.
//   Throughput: one character per cycle while the receiver is ready, set
//   by the single output register; passed bytes thus stream at one per
//   cycle. A new byte is accepted in the cycle the previous byte's last
//   character moves to the output register.
//   Reset clears the valid flags of the holding and output registers and
//   the run index; no item is pending afterward.
//   When the receiver stalls, the output register holds its character and
//   the holding register keeps the current byte, so in_i stalls at most
//   one byte later.
// ----------------------------------------------------------------------------
module url_percent_encoder import upe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  upe_in_if.sink    in_i,
  upe_out_if.source out_o
);

  logic             hold_vld_q;
  logic [ByteW-1:0] hold_byte_q;
  logic [IdxW-1:0]  idx_q;
  logic             out_vld_q;
  logic [CharW-1:0] out_char_q;
  logic             out_last_q;

  upe_char_t gen;
  logic      out_load;
  logic      in_fire;

  upe_char_gen u_char_gen (
    .byte_i (hold_byte_q),
    .idx_i  (idx_q),
    .char_o (gen)
  );

  assign out_load   = hold_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !hold_vld_q || (out_load && gen.last);
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      idx_q      <= '0;
    end else if (in_fire) begin
      hold_vld_q <= 1'b1;
      idx_q      <= '0;
    end else if (out_load) begin
      // Advance within the run, drop the byte after its last character
      if (gen.last) begin
        hold_vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hold_byte_q <= in_i.in_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q <= gen.chr;
      out_last_q <= gen.last;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.out_char = out_char_q;
  assign out_o.run_last = out_last_q;

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> idx_q <= IdxLastSix)
    else $error("run index out of range");

  a_idx_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !gen.last && !in_fire) |=> hold_vld_q && idx_q == $past(idx_q) + 3'd1)
    else $error("run index did not advance");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> hold_vld_q && idx_q == '0)
    else $error("accepted byte did not start a new run");

  a_out_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_char_q >= 7'd33 && out_char_q <= 7'd126))
    else $error("output character not printable");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the URL percent encoder
// Feeds bytes through the input channel with random gaps, predicts each
// byte's character run as it is accepted, and checks every character and
// its run_last flag against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  import upe_pkg::*;

  localparam int unsigned NumRandom  = 345;
  localparam int unsigned IdlePct    = 16;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 16;
  localparam logic [127:0] HexLut    = "0123456789abcdef";

  typedef struct {
    logic [ByteW-1:0] value;
    bit               wait_empty;  // hold until the encoder has drained
  } byte_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  upe_in_if  byte_ch ();
  upe_out_if char_ch ();

  url_percent_encoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (char_ch)
  );

  byte_req_t   byte_q[$];
  upe_char_t   char_q[$];
  int unsigned bytes_taken = 0;
  int unsigned err_cnt     = 0;
  int unsigned quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Encoding predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_unreserved(input logic [ByteW-1:0] b);
    if (b >= "A" && b <= "Z") return 1'b1;
    if (b >= "a" && b <= "z") return 1'b1;
    if (b >= "0" && b <= "9") return 1'b1;
    case (b)
      "-", "_", ".", "!", "~", "*", "'", "(", ")": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic upe_class_e byte_class(input logic [ByteW-1:0] b);
    if (is_unreserved(b)) return ClsPass;
    if (b == " ") return ClsSpace;
    if (!b[ByteW-1]) return ClsEscAscii;
    return ClsEscLatin;
  endfunction

  function automatic logic [CharW-1:0] nibble_char(input logic [3:0] nib);
    int unsigned idx;
    idx = 15 - nib;
    return HexLut[idx*8 +: CharW];
  endfunction

  task automatic push_escape(input logic [ByteW-1:0] b, input logic last);
    char_q.push_back('{chr: ChrPercent, last: 1'b0});
    char_q.push_back('{chr: nibble_char(b[7:4]), last: 1'b0});
    char_q.push_back('{chr: nibble_char(b[3:0]), last: last});
  endtask

  task automatic push_encoding(input logic [ByteW-1:0] b);
    case (byte_class(b))
      ClsPass:     char_q.push_back('{chr: b[CharW-1:0], last: 1'b1});
      ClsSpace:    char_q.push_back('{chr: ChrPlus, last: 1'b1});
      ClsEscAscii: push_escape(b, 1'b1);
      default: begin
        // Latin-1 code point as two UTF-8 bytes
        push_escape(Utf8Lead | {6'd0, b[7:6]}, 1'b0);
        push_escape(Utf8Cont | (b & Utf8Mask), 1'b1);
      end
    endcase
  endtask

  // No idling on either side over a stretch in the middle of the run
  function automatic bit steady_phase();
    return bytes_taken >= 150 && bytes_taken < 260;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_ch.valid   <= 1'b0;
      byte_ch.in_byte <= '0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        push_encoding(byte_ch.in_byte);
        bytes_taken++;
      end
      if (!byte_ch.valid || byte_ch.ready) begin
        if (byte_q.size() == 0) begin
          byte_ch.valid <= 1'b0;
        end else if (byte_q[0].wait_empty && char_q.size() != 0) begin
          byte_ch.valid <= 1'b0;
        end else if (!steady_phase() && $urandom_range(99) < IdlePct) begin
          byte_ch.valid <= 1'b0;
        end else begin
          byte_ch.valid   <= 1'b1;
          byte_ch.in_byte <= byte_q.pop_front().value;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Character monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    upe_char_t want;
    if (!rst_ni) begin
      char_ch.ready <= 1'b0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        if (char_q.size() == 0) begin
          $error("unexpected character %h (run_last %b)", char_ch.out_char,
                 char_ch.run_last);
          err_cnt++;
        end else begin
          want = char_q.pop_front();
          if (char_ch.out_char !== want.chr) begin
            $error("out_char: expected %h, got %h", want.chr, char_ch.out_char);
            err_cnt++;
          end
          if (char_ch.run_last !== want.last) begin
            $error("run_last: expected %b, got %b", want.last, char_ch.run_last);
            err_cnt++;
          end
        end
      end
      char_ch.ready <= steady_phase() || ($urandom_range(99) >= IdlePct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [ByteW-1:0] corner_bytes [25];
    logic [ByteW-1:0] b;
    int unsigned      pick;

    rst_ni = 1'b0;

    // Range ends, Latin-1 boundaries, every mark, space and escaped neighbors
    corner_bytes = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'hC0, 8'hBF, "A", "Z", "a", "z",
                     "0", "9", "-", "_", ".", "!", "~", "*", "'", "(", ")", " ",
                     "%", "+", "/"};
    foreach (corner_bytes[i]) begin
      byte_q.push_back('{value: corner_bytes[i], wait_empty: 1'b0});
    end

    for (int i = 0; i < NumRandom; i++) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        do begin
          b = 8'($urandom_range(127));
        end while (!is_unreserved(b));
      end else if (pick < 6) begin
        b = 8'($urandom_range(127));
      end else begin
        b = 8'($urandom_range(255));
      end
      byte_q.push_back('{value: b, wait_empty: (i == 0 || i == 180 || i == 300)});
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (byte_q.size() != 0 || byte_ch.valid || char_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
